[rtl/drfr_pkg.sv]
// shared types and constants of the door-bus frame receiver
// no dependencies; imported by every other file of the block

package drfr_pkg;

   // frame start bytes and header offsets
   localparam logic [7:0] DOOR_ID_A_LO     = 8'h71;
   localparam logic [7:0] DOOR_ID_A_HI     = 8'h78;
   localparam logic [7:0] DOOR_ID_B_LO     = 8'hC1;
   localparam logic [7:0] DOOR_ID_B_HI     = 8'hC8;
   localparam logic [7:0] DOOR_ADDR_OFFSET = 8'h20;

   // crc-8, reflected form of polynomial 0x07
   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_POLY = 8'hE0;

   // frame lengths and counts
   localparam logic [2:0] LEN_SIX       = 3'd6;
   localparam logic [2:0] LEN_FOUR      = 3'd4;
   localparam logic [2:0] LEN_DOOR      = 3'd5;
   localparam logic [2:0] COUNT_NO_DOOR = 3'd4;

   // reply beats, numbered from zero
   localparam logic [2:0] BEAT_HEADER = 3'd0;
   localparam logic [2:0] BEAT_STATUS = 3'd1;
   localparam logic [2:0] BEAT_LAST   = 3'd6;

   // command flag positions
   localparam int FLAG_OPEN        = 0;
   localparam int FLAG_CLOSE       = 1;
   localparam int FLAG_LEVELING    = 2;
   localparam int FLAG_OPEN_LIMIT  = 3;
   localparam int FLAG_CLOSE_LIMIT = 4;

   // data bits of a four-byte frame
   localparam int D_LEVELING    = 2;
   localparam int D_OPEN_LIMIT  = 4;
   localparam int D_CLOSE_LIMIT = 5;

   typedef enum logic [2:0] {
      EV_NONE     = 3'd0,
      EV_CRC_GOOD = 3'd1,
      EV_CRC_BAD  = 3'd2,
      EV_XOR_GOOD = 3'd3,
      EV_XOR_BAD  = 3'd4
   } frame_event_type;

   typedef enum logic [2:0] {
      DS_NORMAL   = 3'd0,
      DS_FAULT    = 3'd1,
      DS_DIST_LRN = 3'd2,
      DS_CLOSE_LRN = 3'd3
   } dev_status_type;

   // controller to datapath
   typedef struct packed {
      logic       capture;
      logic       commit;
      logic       load;
      logic [2:0] beat;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic send;
   } dp_status_type;

endpackage

[rtl/drfr_dp.sv]
// datapath of the door-bus frame receiver: frame state, running checks,
// status flags and result register; depends on drfr_pkg

module drfr_dp
   import drfr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_valid,
   input  logic [7:0]    csr_sensor_address,
   input  logic [7:0]    req_rx_byte,
   input  logic [2:0]    req_device_status,
   input  logic          req_obstacle_io,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status,
   output logic          rsp_kind,
   output logic [7:0]    rsp_tx_byte,
   output logic          rsp_last,
   output logic [2:0]    rsp_frame_event,
   output logic          rsp_open_door_cmd,
   output logic          rsp_close_door_cmd,
   output logic          rsp_leveling,
   output logic          rsp_open_limit,
   output logic          rsp_close_limit,
   output logic          rsp_master_leveling,
   output logic          rsp_link_seen
);

   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic dev_status_type req_status_code(input logic [2:0] code);
      return dev_status_type'(code);
   endfunction

   // captured input item
   logic [7:0] rx_ff;
   logic [2:0] dev_status_ff;
   logic       obstacle_ff;

   logic [7:0] address_ff;

   // frame state
   logic       header_ff, header_in;
   logic [2:0] count_ff, count_in;
   logic [2:0] length_ff, length_in;
   logic       door_ff, door_in;
   logic       phase_ff, phase_in;
   logic [7:0] crc_ff, crc_in;
   logic [7:0] xor_ff, xor_in;
   logic [7:0] byte0_ff, byte0_in;
   logic [7:0] byte1_ff, byte1_in;

   // status flags
   logic [4:0] flags_ff, flags_in;
   logic       master_ff, master_in;
   logic [1:0] rsb_ff, rsb_in;
   logic       link_ff, link_in;

   // outcome of the last item
   frame_event_type event_ff, event_in;
   logic       send_ff, send_in;
   logic [7:0] reply0_ff, reply1_ff, reply1_in;

   // result register
   logic       kind_ff;
   logic [7:0] tx_ff;
   logic       last_ff;
   frame_event_type rsp_event_ff;
   logic [4:0] rsp_flags_ff;
   logic       rsp_master_ff;
   logic       rsp_link_ff;
   logic [7:0] beat_byte;

   logic       start_addr, start_door, in_frame, complete;
   logic [2:0] cnt0, cnt1;
   logic [7:0] crc_prev, xor_prev;

   always_comb begin
      start_addr = (rx_ff == address_ff);
      // an address match restarts the count, so a door id then starts a door frame
      start_door = (rx_ff inside {[DOOR_ID_A_LO:DOOR_ID_A_HI], [DOOR_ID_B_LO:DOOR_ID_B_HI]})
                   && ((count_ff != COUNT_NO_DOOR) || start_addr);
      in_frame   = header_ff | start_addr | start_door;
      cnt0       = (start_addr | start_door) ? 3'd0 : count_ff;
      cnt1       = cnt0 + 3'd1;

      door_in    = start_door ? 1'b1 : (start_addr ? 1'b0 : door_ff);
      length_in  = start_door ? LEN_DOOR :
                   (start_addr ? (phase_ff ? LEN_SIX : LEN_FOUR) : length_ff);
      complete   = in_frame && (cnt1 >= length_in);

      // running checks cover the bytes before this one
      crc_prev   = (cnt0 == 3'd0) ? CRC_INIT : crc_ff;
      xor_prev   = (cnt0 == 3'd0) ? 8'h00 : xor_ff;
      crc_in     = crc8_byte(crc_prev, rx_ff);
      xor_in     = xor_prev ^ rx_ff;
      byte0_in   = (cnt0 == 3'd0) ? rx_ff : byte0_ff;
      byte1_in   = (cnt0 == 3'd1) ? rx_ff : byte1_ff;

      header_in  = header_ff;
      count_in   = count_ff;
      phase_in   = phase_ff;
      flags_in   = flags_ff;
      master_in  = master_ff;
      rsb_in     = rsb_ff;
      link_in    = link_ff;
      event_in   = EV_NONE;
      send_in    = 1'b0;

      if (in_frame && !complete) begin
         header_in = 1'b1;
         count_in  = cnt1;
      end else if (complete) begin
         header_in = 1'b0;
         count_in  = 3'd0;
         link_in   = 1'b1;
         if (door_in && (byte0_in == address_ff + DOOR_ADDR_OFFSET)) begin
            if (xor_prev == rx_ff) begin
               event_in  = EV_XOR_GOOD;
               send_in   = 1'b1;
               master_in = byte1_in[0];
               case (req_status_code(dev_status_ff))
                  DS_NORMAL:                 rsb_in = 2'd0;
                  DS_FAULT:                  rsb_in = 2'd1;
                  DS_DIST_LRN, DS_CLOSE_LRN: rsb_in = 2'd2;
                  default:                   rsb_in = rsb_ff;
               endcase
            end else begin
               event_in = EV_XOR_BAD;
            end
         end else if (~crc_prev == rx_ff) begin
            event_in = EV_CRC_GOOD;
            phase_in = ~phase_ff;
            if (phase_ff) begin
               flags_in[FLAG_OPEN]  = byte1_in[0];
               flags_in[FLAG_CLOSE] = byte1_in[1];
            end else begin
               flags_in[FLAG_LEVELING]    = ~byte1_in[D_LEVELING];
               flags_in[FLAG_OPEN_LIMIT]  = ~byte1_in[D_OPEN_LIMIT];
               flags_in[FLAG_CLOSE_LIMIT] = byte1_in[D_CLOSE_LIMIT];
            end
         end else begin
            event_in = EV_CRC_BAD;
         end
      end

      reply1_in = {obstacle_ff, 5'd0, rsb_in};
   end

   always_comb begin
      case (cmd.beat)
         BEAT_HEADER: beat_byte = reply0_ff;
         BEAT_STATUS: beat_byte = reply1_ff;
         BEAT_LAST:   beat_byte = reply0_ff ^ reply1_ff;
         default:     beat_byte = 8'h00;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         address_ff <= 8'h00;
         header_ff  <= 1'b0;
         count_ff   <= 3'd0;
         length_ff  <= LEN_SIX;
         door_ff    <= 1'b0;
         phase_ff   <= 1'b1;
         flags_ff   <= 5'd0;
         master_ff  <= 1'b0;
         rsb_ff     <= 2'd0;
         link_ff    <= 1'b0;
         send_ff    <= 1'b0;
      end else begin
         if (csr_valid) begin
            address_ff <= csr_sensor_address;
         end
         if (cmd.commit) begin
            header_ff <= header_in;
            count_ff  <= count_in;
            length_ff <= length_in;
            door_ff   <= door_in;
            phase_ff  <= phase_in;
            flags_ff  <= flags_in;
            master_ff <= master_in;
            rsb_ff    <= rsb_in;
            link_ff   <= link_in;
            send_ff   <= send_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rx_ff         <= req_rx_byte;
         dev_status_ff <= req_device_status;
         obstacle_ff   <= req_obstacle_io;
      end
      if (cmd.commit) begin
         crc_ff    <= crc_in;
         xor_ff    <= xor_in;
         byte0_ff  <= byte0_in;
         byte1_ff  <= byte1_in;
         event_ff  <= event_in;
         reply0_ff <= byte0_in;
         reply1_ff <= reply1_in;
      end
      if (cmd.load) begin
         kind_ff       <= send_ff;
         tx_ff         <= send_ff ? beat_byte : 8'h00;
         last_ff       <= !send_ff || (cmd.beat == BEAT_LAST);
         rsp_event_ff  <= event_ff;
         rsp_flags_ff  <= flags_ff;
         rsp_master_ff <= master_ff;
         rsp_link_ff   <= link_ff;
      end
   end

   assign status.send         = send_ff;
   assign rsp_kind            = kind_ff;
   assign rsp_tx_byte         = tx_ff;
   assign rsp_last            = last_ff;
   assign rsp_frame_event     = rsp_event_ff;
   assign rsp_open_door_cmd   = rsp_flags_ff[FLAG_OPEN];
   assign rsp_close_door_cmd  = rsp_flags_ff[FLAG_CLOSE];
   assign rsp_leveling        = rsp_flags_ff[FLAG_LEVELING];
   assign rsp_open_limit      = rsp_flags_ff[FLAG_OPEN_LIMIT];
   assign rsp_close_limit     = rsp_flags_ff[FLAG_CLOSE_LIMIT];
   assign rsp_master_leveling = rsp_master_ff;
   assign rsp_link_seen       = rsp_link_ff;

endmodule

[rtl/drfr_ctrl.sv]
// controller of the door-bus frame receiver: input handshake, evaluation
// step and result sequencing; depends on drfr_pkg

module drfr_ctrl
   import drfr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_SEND
   } state_type;

   state_type  state_ff;
   logic [2:0] beat_ff;
   logic       valid_ff;
   logic       out_free;
   logic       done;

   always_comb begin
      // result register empty, or emptied by this transfer
      out_free    = !valid_ff || !rsp_stall;
      done        = !status.send || (beat_ff == BEAT_LAST);
      cmd.capture = (state_ff == ST_IDLE) && req_valid;
      cmd.commit  = (state_ff == ST_EVAL);
      cmd.load    = (state_ff == ST_SEND) && out_free;
      cmd.beat    = beat_ff;
      req_stall   = (state_ff != ST_IDLE);
      rsp_valid   = valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         beat_ff  <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               beat_ff <= 3'd0;
               if (req_valid) begin
                  state_ff <= ST_EVAL;
               end
            end
            ST_EVAL: begin
               state_ff <= ST_SEND;
            end
            ST_SEND: begin
               if (out_free) begin
                  if (done) begin
                     beat_ff  <= 3'd0;
                     state_ff <= ST_IDLE;
                  end else begin
                     beat_ff <= beat_ff + 3'd1;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

[rtl/rs485_door_frame_receiver_core.sv]
// top level of the door-bus frame receiver
// instantiates drfr_ctrl and drfr_dp; depends on drfr_pkg
//
// Usage:
// - req_ channel: one received bus byte per transfer, with the device status
//   and obstacle input sampled alongside it.
// - rsp_ channel: every byte gives one status result (kind 0), except the
//   byte that completes a door frame with a good xor, which gives the seven
//   reply bytes (kind 1) in order; rsp_last marks the final result of a byte.
// - csr_ channel: writes the sensor address; csr_ready is always high. Write
//   it only while no byte is in flight.
// - Timing: a byte is captured while idle, checked in the evaluate step and
//   then loaded result by result into the one-beat result register; no new
//   byte is taken until its last result is loaded, but the next byte is taken
//   while the last result still waits.
// - rsp_stall holds the result register and the sequencer; req_stall then
//   stays high until the last result of the byte is in the result register.
// - Reset clears frame state, flags and the sensor address and empties the
//   result register.

module rs485_door_frame_receiver_core
   import drfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_sensor_address,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic [2:0] req_device_status,
   input  logic       req_obstacle_io,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_kind,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_last,
   output logic [2:0] rsp_frame_event,
   output logic       rsp_open_door_cmd,
   output logic       rsp_close_door_cmd,
   output logic       rsp_leveling,
   output logic       rsp_open_limit,
   output logic       rsp_close_limit,
   output logic       rsp_master_leveling,
   output logic       rsp_link_seen
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   drfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   drfr_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid && csr_ready),
      .csr_sensor_address  (csr_sensor_address),
      .req_rx_byte         (req_rx_byte),
      .req_device_status   (req_device_status),
      .req_obstacle_io     (req_obstacle_io),
      .cmd                 (cmd),
      .status              (status),
      .rsp_kind            (rsp_kind),
      .rsp_tx_byte         (rsp_tx_byte),
      .rsp_last            (rsp_last),
      .rsp_frame_event     (rsp_frame_event),
      .rsp_open_door_cmd   (rsp_open_door_cmd),
      .rsp_close_door_cmd  (rsp_close_door_cmd),
      .rsp_leveling        (rsp_leveling),
      .rsp_open_limit      (rsp_open_limit),
      .rsp_close_limit     (rsp_close_limit),
      .rsp_master_leveling (rsp_master_leveling),
      .rsp_link_seen       (rsp_link_seen)
   );

   // a status result is always the only one of its byte
   a_status_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_kind |-> rsp_last && (rsp_tx_byte == 8'h00))
      else $error("status result not alone or carries data");

   // reply bytes only follow a good door frame
   a_reply_event : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind |-> rsp_frame_event == EV_XOR_GOOD)
      else $error("reply byte without good xor");

   // one byte at a time: a transfer on req_ blocks the next edge
   a_one_in_flight : assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second byte taken while one is in flight");

   // a frame event always marks the link as seen
   a_link_on_event : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_frame_event != EV_NONE) |-> rsp_link_seen)
      else $error("frame event without link flag");

endmodule

[test/tb_rs485_door_frame_receiver_core.sv]
// self-checking testbench for rs485_door_frame_receiver_core: byte stream in, status and reply out
// depends on drfr_pkg and the rtl of the block; carries its own model of the frame receiver

module tb_rs485_door_frame_receiver_core;
   import drfr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT    = 400000;
   localparam int DRAIN_CYCLES   = 12;
   localparam int ITEMS_PER_MODE = 44;

   typedef struct packed {
      logic [7:0] rx;
      logic [2:0] status;
      logic       obst;
   } bus_byte_type;

   typedef struct packed {
      logic            kind;
      logic [7:0]      tx;
      logic            last;
      frame_event_type ev;
      logic [4:0]      cmd;
      logic            master;
      logic            link;
   } rx_result_type;

   typedef struct packed {
      logic [7:0]      addr;
      logic            hdr_open;
      logic [2:0]      count;
      logic [2:0]      flen;
      logic            door;
      logic            six_phase;
      logic [0:5][7:0] store;
      logic [4:0]      cmd;
      logic            master;
      logic [1:0]      reply_stat;
      logic            link;
   } rx_state_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_sensor_address = 8'h00;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'h00;
   logic [2:0] req_device_status = 3'd0;
   logic       req_obstacle_io = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_kind;
   logic [7:0] rsp_tx_byte;
   logic       rsp_last;
   logic [2:0] rsp_frame_event;
   logic       rsp_open_door_cmd;
   logic       rsp_close_door_cmd;
   logic       rsp_leveling;
   logic       rsp_open_limit;
   logic       rsp_close_limit;
   logic       rsp_master_leveling;
   logic       rsp_link_seen;

   bus_byte_type  bytes_pending[$];
   rx_result_type results_awaited[$];
   rx_state_type  rx_now;
   rx_state_type  rx_plan;
   bus_byte_type  byte_on_bus;
   int         queued_count = 0;
   int         accepted_count = 0;
   int         errors = 0;
   int         cycles = 0;
   int         burst_left = 0;
   int         gap_left = 0;
   int         taken_made = 0;
   logic [15:0] stall_tick = 16'd0;

   frame_event_type  step_ev;
   logic             step_send;
   logic [0:6][7:0]  step_reply;

   rs485_door_frame_receiver_core u_top (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_sensor_address  (csr_sensor_address),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_rx_byte         (req_rx_byte),
      .req_device_status   (req_device_status),
      .req_obstacle_io     (req_obstacle_io),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_kind            (rsp_kind),
      .rsp_tx_byte         (rsp_tx_byte),
      .rsp_last            (rsp_last),
      .rsp_frame_event     (rsp_frame_event),
      .rsp_open_door_cmd   (rsp_open_door_cmd),
      .rsp_close_door_cmd  (rsp_close_door_cmd),
      .rsp_leveling        (rsp_leveling),
      .rsp_open_limit      (rsp_open_limit),
      .rsp_close_limit     (rsp_close_limit),
      .rsp_master_leveling (rsp_master_leveling),
      .rsp_link_seen       (rsp_link_seen)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic is_door_id(input logic [7:0] b);
      return (b >= DOOR_ID_A_LO && b <= DOOR_ID_A_HI) ||
             (b >= DOOR_ID_B_LO && b <= DOOR_ID_B_HI);
   endfunction

   function automatic logic [7:0] crc8_of(input logic [0:5][7:0] f, input int n);
      logic [7:0] c;
      c = CRC_INIT;
      for (int i = 0; i < n; i++) begin
         c = c ^ f[i];
         for (int b = 0; b < 8; b++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return ~c;
   endfunction

   function automatic rx_state_type state_after_reset();
      rx_state_type s;
      s = '0;
      s.flen = LEN_SIX;
      s.six_phase = 1'b1;
      return s;
   endfunction

   // one received byte through the frame receiver: next state, event and reply
   function automatic rx_state_type receive_byte(input rx_state_type s, input bus_byte_type it,
                                                 output frame_event_type ev, output logic send,
                                                 output logic [0:6][7:0] reply);
      rx_state_type n;
      logic [7:0] door_hdr;
      logic [7:0] d;
      n = s;
      ev = EV_NONE;
      send = 1'b0;
      reply = '0;
      door_hdr = n.addr + DOOR_ADDR_OFFSET;
      if (it.rx == n.addr) begin
         n.hdr_open = 1'b1;
         n.count = 3'd0;
         n.door = 1'b0;
         n.flen = n.six_phase ? LEN_SIX : LEN_FOUR;
      end
      // a door id in the fifth slot is plain data
      if (is_door_id(it.rx) && n.count != COUNT_NO_DOOR) begin
         n.hdr_open = 1'b1;
         n.count = 3'd0;
         n.door = 1'b1;
         n.flen = LEN_DOOR;
      end
      if (n.hdr_open) begin
         if (n.count < 3'd6)
            n.store[n.count] = it.rx;
         n.count = n.count + 3'd1;
         if (n.count >= n.flen) begin
            n.link = 1'b1;
            if (n.door && n.store[0] == door_hdr) begin
               if ((n.store[0] ^ n.store[1] ^ n.store[2] ^ n.store[3]) == n.store[4]) begin
                  ev = EV_XOR_GOOD;
                  n.master = n.store[1][0];
                  case (it.status)
                     DS_NORMAL:                 n.reply_stat = 2'd0;
                     DS_FAULT:                  n.reply_stat = 2'd1;
                     DS_DIST_LRN, DS_CLOSE_LRN: n.reply_stat = 2'd2;
                     default:                   ;
                  endcase
                  reply[0] = n.store[0];
                  reply[1] = {it.obst, 5'b0, n.reply_stat};
                  reply[6] = reply[0] ^ reply[1];
                  send = 1'b1;
               end else begin
                  ev = EV_XOR_BAD;
               end
            end else if (crc8_of(n.store, n.flen - 1) == n.store[n.flen - 1]) begin
               ev = EV_CRC_GOOD;
               d = n.store[1];
               if (n.six_phase) begin
                  n.cmd[FLAG_OPEN]  = d[0];
                  n.cmd[FLAG_CLOSE] = d[1];
               end else begin
                  n.cmd[FLAG_LEVELING]    = ~d[D_LEVELING];
                  n.cmd[FLAG_OPEN_LIMIT]  = ~d[D_OPEN_LIMIT];
                  n.cmd[FLAG_CLOSE_LIMIT] = d[D_CLOSE_LIMIT];
               end
               n.six_phase = ~n.six_phase;
            end else begin
               ev = EV_CRC_BAD;
            end
            n.hdr_open = 1'b0;
            n.count = 3'd0;
            n.store = '0;
         end
      end
      return n;
   endfunction

   function automatic rx_result_type status_result(input logic kind, input logic [7:0] tx,
                                                   input logic last, input frame_event_type ev);
      rx_result_type r;
      r.kind = kind;
      r.tx = tx;
      r.last = last;
      r.ev = ev;
      r.cmd = rx_now.cmd;
      r.master = rx_now.master;
      r.link = rx_now.link;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (want !== got) begin
         $display("%0t mismatch on %s: expected %0h actual %0h", $time, name, want, got);
         errors++;
      end
   endfunction

   // sender: bursts of transfers separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            accepted_count++;
            rx_now = receive_byte(rx_now, byte_on_bus, step_ev, step_send, step_reply);
            if (step_send) begin
               for (int k = 0; k < 7; k++)
                  results_awaited.push_back(status_result(1'b1, step_reply[k], k == 6, step_ev));
            end else begin
               results_awaited.push_back(status_result(1'b0, 8'h00, 1'b1, step_ev));
            end
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (bytes_pending.size() > 0) begin
               byte_on_bus = bytes_pending.pop_front();
               req_valid <= 1'b1;
               req_rx_byte <= byte_on_bus.rx;
               req_device_status <= byte_on_bus.status;
               req_obstacle_io <= byte_on_bus.obst;
               if (burst_left > 0)
                  burst_left--;
               if (burst_left == 0) begin
                  if ($urandom_range(0, 9) == 0) begin
                     burst_left = 60;
                     gap_left = 0;
                  end else begin
                     burst_left = $urandom_range(1, 16);
                     gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                  end
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall, changing its character with bits 9:8 of a free-running tick counter
   always @(posedge clock) begin
      stall_tick <= stall_tick + 16'd1;
      case (stall_tick[9:8])
         2'd0:    rsp_stall <= 1'b0;
         2'd1:    rsp_stall <= ($urandom_range(0, 2) == 0);
         2'd2:    rsp_stall <= (stall_tick[2:0] < 3'd3);
         default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   always @(posedge clock) begin
      rx_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (results_awaited.size() == 0) begin
            $display("%0t unexpected result: expected none actual kind %0h tx %0h event %0h",
                     $time, rsp_kind, rsp_tx_byte, rsp_frame_event);
            errors++;
         end else begin
            want = results_awaited.pop_front();
            check_field("kind", 8'(want.kind), 8'(rsp_kind));
            check_field("tx_byte", want.tx, rsp_tx_byte);
            check_field("last", 8'(want.last), 8'(rsp_last));
            check_field("frame_event", 8'(want.ev), 8'(rsp_frame_event));
            check_field("open_door_cmd", 8'(want.cmd[FLAG_OPEN]), 8'(rsp_open_door_cmd));
            check_field("close_door_cmd", 8'(want.cmd[FLAG_CLOSE]), 8'(rsp_close_door_cmd));
            check_field("leveling", 8'(want.cmd[FLAG_LEVELING]), 8'(rsp_leveling));
            check_field("open_limit", 8'(want.cmd[FLAG_OPEN_LIMIT]), 8'(rsp_open_limit));
            check_field("close_limit", 8'(want.cmd[FLAG_CLOSE_LIMIT]), 8'(rsp_close_limit));
            check_field("master_leveling", 8'(want.master), 8'(rsp_master_leveling));
            check_field("link_seen", 8'(want.link), 8'(rsp_link_seen));
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t timeout: %0d results still awaited", $time, results_awaited.size());
         $display("FAIL rs485_door_frame_receiver_core");
         $finish;
      end
   end

   task automatic queue_byte(input logic [7:0] b, input logic [2:0] st, input logic ob);
      bus_byte_type     it;
      frame_event_type  ev;
      logic             send;
      logic [0:6][7:0]  reply;
      it.rx = b;
      it.status = st;
      it.obst = ob;
      bytes_pending.push_back(it);
      queued_count++;
      rx_plan = receive_byte(rx_plan, it, ev, send, reply);
      if (rx_plan.hdr_open || ev != EV_NONE)
         taken_made++;
   endtask

   // completes the check byte for the frame length the receiver will expect
   task automatic queue_frame(input logic [0:5][7:0] f, input logic corrupt,
                              input logic [2:0] last_status, input logic last_obst);
      int         len;
      logic [7:0] door_hdr;
      door_hdr = rx_plan.addr + DOOR_ADDR_OFFSET;
      len = int'(is_door_id(f[0]) ? LEN_DOOR : (rx_plan.six_phase ? LEN_SIX : LEN_FOUR));
      if (is_door_id(f[0]) && f[0] == door_hdr)
         f[4] = f[0] ^ f[1] ^ f[2] ^ f[3];
      else
         f[len - 1] = crc8_of(f, len - 1);
      if (corrupt)
         f[len - 1] = f[len - 1] ^ (8'h01 << $urandom_range(0, 7));
      for (int i = 0; i < len - 1; i++)
         queue_byte(f[i], 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
      queue_byte(f[len - 1], last_status, last_obst);
   endtask

   // frame data, mostly steering clear of bytes that would restart the frame
   function automatic logic [7:0] data_byte(input int pos);
      logic [7:0] b;
      b = 8'($urandom);
      while ((b == rx_plan.addr || (is_door_id(b) && pos != 4)) && $urandom_range(0, 7) != 0)
         b = 8'($urandom);
      return b;
   endfunction

   function automatic logic [7:0] any_door_id();
      return ($urandom_range(0, 1) ? DOOR_ID_A_LO : DOOR_ID_B_LO) + 8'($urandom_range(0, 7));
   endfunction

   task automatic wait_idle();
      while (accepted_count != queued_count || results_awaited.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_sensor_address(input logic [7:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_sensor_address <= v;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      rx_now.addr = v;
      rx_plan.addr = v;
   endtask

   task automatic random_traffic(input int target);
      logic [0:5][7:0] f;
      logic [7:0]      door_hdr;
      int              r;
      int              extra;
      taken_made = 0;
      door_hdr = rx_plan.addr + DOOR_ADDR_OFFSET;
      while (taken_made < target) begin
         r = $urandom_range(0, 99);
         f = '0;
         for (int p = 1; p < 6; p++)
            f[p] = data_byte(p);
         if (r < 35) begin
            f[0] = rx_plan.addr;
         end else if (r < 65) begin
            f[0] = is_door_id(door_hdr) ? door_hdr : any_door_id();
         end else begin
            f[0] = any_door_id();
         end
         if (r < 78) begin
            queue_frame(f, $urandom_range(0, 99) < 15, 3'($urandom_range(0, 7)),
                        1'($urandom_range(0, 1)));
         end else if (r < 88) begin
            // frame cut short, the next start byte takes over
            extra = $urandom_range(0, 3);
            for (int i = 0; i <= extra; i++)
               queue_byte(f[i], 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
         end else begin
            extra = $urandom_range(1, 3);
            for (int i = 0; i < extra; i++)
               queue_byte(8'($urandom), 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
         end
      end
   endtask

   initial begin
      logic [7:0] addr_modes[8];
      rx_now = state_after_reset();
      rx_plan = state_after_reset();
      addr_modes = '{8'hA8, 8'h00, 8'h58, 8'hFF, 8'h75, 8'hA1, 8'h51, 8'h00};
      addr_modes[7] = 8'($urandom_range(0, 255));
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // door header becomes 0x71 with this address
      write_sensor_address(8'h51);
      queue_byte(8'h00, 3'd7, 1'b1);
      queue_frame({8'h51, 8'h03, 8'hFF, 8'h00, 8'h78, 8'h00}, 1'b0, 3'd5, 1'b0);
      queue_frame({8'h51, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, 3'd0, 1'b1);
      queue_byte(8'h71, 3'd2, 1'b0);
      queue_byte(8'h33, 3'd4, 1'b1);
      queue_frame({8'h71, 8'h01, 8'h5A, 8'hA5, 8'h00, 8'h00}, 1'b0, 3'd2, 1'b1);
      queue_frame({8'h71, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 3'd1, 1'b0);
      queue_frame({8'h51, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00}, 1'b1, 3'd3, 1'b1);
      wait_idle();

      foreach (addr_modes[m]) begin
         write_sensor_address(addr_modes[m]);
         random_traffic(ITEMS_PER_MODE);
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && results_awaited.size() == 0) begin
         $display("PASS rs485_door_frame_receiver_core");
      end else begin
         $display("FAIL rs485_door_frame_receiver_core");
      end
      $finish;
   end

endmodule

[files.f]
rtl/drfr_pkg.sv
rtl/drfr_dp.sv
rtl/drfr_ctrl.sv
rtl/rs485_door_frame_receiver_core.sv
test/tb_rs485_door_frame_receiver_core.sv
